@@ src/two_point_aim_transform_top_defines.svh @@
// Assertion macros for the two-point aim transform.
// Included by the top level; depends on nothing else.
`ifndef TWO_POINT_AIM_TRANSFORM_TOP_DEFINES_SVH
`define TWO_POINT_AIM_TRANSFORM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define TPAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define TPAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TPAT_ASSERT_NOW(label, clk, rst, ante, cons)
`define TPAT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/tpat_pkg.sv @@
// Shared constants and types of the two-point aim transform.
// Used by tpat_vnorm and the top level; depends on nothing.
package tpat_pkg;

   // Lane format of the packed 63-bit words.
   localparam int CB         = 21;
   localparam int WORD       = 63;
   localparam int BASIS_FRAC = CB - 4;

   // Normalizer datapath widths.
   localparam int NV       = 40;                 // signed input vector lane
   localparam int PW       = $clog2(NV);         // bit position of a lane
   localparam int NORM_LO  = 24;                 // target leading-one position
   localparam int MW       = NORM_LO + 1;        // prescaled magnitude
   localparam int SQ_STEPS = 30;                 // root bits
   localparam int SQW      = 2 * SQ_STEPS + 1;   // radicand and root work width
   localparam int DVW      = SQ_STEPS + 2;       // divisor, twice the root
   localparam int QB       = BASIS_FRAC + 1;     // quotient bits
   localparam int RW       = DVW + QB;           // remainder width
   localparam int OW       = QB + 1;             // signed unit component
   localparam int NORM_LAT = 6 + SQ_STEPS + 1 + QB + 1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OFF_COL_X  = 3'd0;
   localparam logic [2:0] CSR_OFF_COL_Y  = 3'd1;
   localparam logic [2:0] CSR_OFF_COL_Z  = 3'd2;
   localparam logic [2:0] CSR_OFF_ORIGIN = 3'd3;

   typedef logic signed [CB-1:0] lane_type;

endpackage

@@ src/tpat_vnorm.sv @@
// Pipelined vector normalizer: prescale, squared length, root, divide.
// Depends on tpat_pkg. Accepts one vector per cycle.
module tpat_vnorm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [2:0][tpat_pkg::NV-1:0]          in_vec,
   output logic                                  out_valid,
   output logic [2:0][tpat_pkg::OW-1:0]          out_vec
);
   import tpat_pkg::*;

   typedef struct packed {
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][MW-1:0]    m;
   } nside_type;

   function automatic logic [PW-1:0] msb_pos(input logic [NV-1:0] v);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < NV; i++) begin
         if (v[i]) p = PW'(i);
      end
      return p;
   endfunction

   logic                 a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic [2:0]           a_neg_ff, b_neg_ff, c_neg_ff;
   logic [NV-1:0]        a_mag_ff [3];
   logic [NV-1:0]        b_mag_ff [3];
   logic [NV-1:0]        c_mag_ff [3];
   logic [NV-1:0]        b_mx_in, b_mx_ff;
   logic [PW-1:0]        c_pos_ff;
   logic                 c_zero_ff;
   logic [NV-1:0]        shl_in [3];
   nside_type            d_side_in, d_side_ff, e_side_ff;
   logic [2*MW-1:0]      e_sq_ff [3];
   logic [SQW-1:0]       sq_x_ff [SQ_STEPS+1];
   logic [SQW-1:0]       sq_r_ff [SQ_STEPS+1];
   nside_type            sq_side_ff [SQ_STEPS+1];
   logic                 sq_valid_ff [SQ_STEPS+1];
   logic [RW-1:0]        dv_r_ff [QB+1][3];
   logic [QB-1:0]        dv_q_ff [QB+1][3];
   logic [DVW-1:0]       dv_d_ff [QB+1];
   nside_type            dv_side_ff [QB+1];
   logic                 dv_valid_ff [QB+1];
   logic [2:0][OW-1:0]   h_vec_ff;
   logic                 h_valid_ff;

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // Largest magnitude of the three lanes.
   always_comb begin
      b_mx_in = a_mag_ff[0];
      if (a_mag_ff[1] > b_mx_in) b_mx_in = a_mag_ff[1];
      if (a_mag_ff[2] > b_mx_in) b_mx_in = a_mag_ff[2];
   end

   // Prescale so that the largest magnitude has its leading one at NORM_LO.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (c_pos_ff > PW'(NORM_LO)) begin
            shl_in[i] = c_mag_ff[i] >> (c_pos_ff - PW'(NORM_LO));
         end else begin
            shl_in[i] = c_mag_ff[i] << (PW'(NORM_LO) - c_pos_ff);
         end
      end
      d_side_in.zero = c_zero_ff;
      d_side_in.neg  = c_neg_ff;
      for (int i = 0; i < 3; i++) begin
         d_side_in.m[i] = shl_in[i][MW-1:0];
      end
   end

   // Front stages: magnitude, maximum, leading one, shift, squares, sum.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_neg_ff[i] <= in_vec[i][NV-1];
         a_mag_ff[i] <= in_vec[i][NV-1] ? (~in_vec[i] + NV'(1)) : in_vec[i];
         b_mag_ff[i] <= a_mag_ff[i];
         c_mag_ff[i] <= b_mag_ff[i];
         e_sq_ff[i]  <= (2*MW)'(d_side_ff.m[i]) * (2*MW)'(d_side_ff.m[i]);
      end
      b_neg_ff      <= a_neg_ff;
      b_mx_ff       <= b_mx_in;
      c_neg_ff      <= b_neg_ff;
      c_pos_ff      <= msb_pos(b_mx_ff);
      c_zero_ff     <= (b_mx_ff == '0);
      d_side_ff     <= d_side_in;
      e_side_ff     <= d_side_ff;
      sq_x_ff[0]    <= SQW'((SQW'(e_sq_ff[0]) + SQW'(e_sq_ff[1]) + SQW'(e_sq_ff[2])) << 8);
      sq_r_ff[0]    <= '0;
      sq_side_ff[0] <= e_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) sq_valid_ff[0] <= 1'b0;
      else       sq_valid_ff[0] <= e_valid_ff;
   end

   // Square root, one result bit per stage.
   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
      localparam logic [SQW-1:0] BITC = SQW'(1) << (2 * (SQ_STEPS - 1 - g));
      logic [SQW-1:0] trial;
      assign trial = sq_r_ff[g] + BITC;
      always_ff @(posedge clock) begin
         if (sq_x_ff[g] >= trial) begin
            sq_x_ff[g+1] <= sq_x_ff[g] - trial;
            sq_r_ff[g+1] <= (sq_r_ff[g] >> 1) + BITC;
         end else begin
            sq_x_ff[g+1] <= sq_x_ff[g];
            sq_r_ff[g+1] <= sq_r_ff[g] >> 1;
         end
         sq_side_ff[g+1] <= sq_side_ff[g];
      end
      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[g+1] <= 1'b0;
         else       sq_valid_ff[g+1] <= sq_valid_ff[g];
      end
   end

   // Division setup: numerator m * 2^22 + s over divisor 2s rounds to nearest.
   always_ff @(posedge clock) begin
      dv_d_ff[0]    <= {sq_r_ff[SQ_STEPS][DVW-2:0], 1'b0};
      dv_side_ff[0] <= sq_side_ff[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
         dv_r_ff[0][i] <= (RW'(sq_side_ff[SQ_STEPS].m[i]) << (BASIS_FRAC + 5))
                          + RW'(sq_r_ff[SQ_STEPS][DVW-2:0]);
         dv_q_ff[0][i] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= sq_valid_ff[SQ_STEPS];
   end

   // Restoring division, one quotient bit per stage for all three lanes.
   for (genvar g = 0; g < QB; g++) begin : g_div
      localparam int SH = QB - 1 - g;
      logic [RW-1:0] dsh;
      assign dsh = RW'(dv_d_ff[g]) << SH;
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_r_ff[g][i] >= dsh) begin
               dv_r_ff[g+1][i] <= dv_r_ff[g][i] - dsh;
               dv_q_ff[g+1][i] <= dv_q_ff[g][i] | (QB'(1) << SH);
            end else begin
               dv_r_ff[g+1][i] <= dv_r_ff[g][i];
               dv_q_ff[g+1][i] <= dv_q_ff[g][i];
            end
         end
         dv_d_ff[g+1]    <= dv_d_ff[g];
         dv_side_ff[g+1] <= dv_side_ff[g];
      end
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[g+1] <= 1'b0;
         else       dv_valid_ff[g+1] <= dv_valid_ff[g];
      end
   end

   // Apply signs; a zero vector gives zero.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side_ff[QB].zero) begin
            h_vec_ff[i] <= '0;
         end else if (dv_side_ff[QB].neg[i]) begin
            h_vec_ff[i] <= OW'(~{1'b0, dv_q_ff[QB][i]} + OW'(1));
         end else begin
            h_vec_ff[i] <= {1'b0, dv_q_ff[QB][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff <= 1'b0;
      else       h_valid_ff <= dv_valid_ff[QB];
   end

   assign out_valid = h_valid_ff;
   assign out_vec   = h_vec_ff;

endmodule

@@ src/two_point_aim_transform_top.sv @@
// Two-point aim transform: aim frame from two hand positions, grip offset applied.
// Depends on tpat_pkg, tpat_vnorm and two_point_aim_transform_top_defines.svh.
//
//   Channel   Ports                       Transfer
//   request   start, busy, req_*          start high while busy low
//   response  rsp_strobe, rsp_*           one cycle per result, no backpressure
//   config    csr_write_en, csr_index,    every cycle with csr_write_en high
//             csr_wdata
//
// One transaction enters every cycle; busy stays low. Each result passes
// through two of the three normalizers in series, each a 30-stage root and an
// 18-stage divider.
// Reset is synchronous; it clears the valid bits and loads the identity offset.
// The receiver cannot stall, so the pipeline never holds.
`include "two_point_aim_transform_top_defines.svh"
module two_point_aim_transform_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tpat_pkg::WORD-1:0]     req_primary_col_x,
   input  logic [tpat_pkg::WORD-1:0]     req_primary_col_y,
   input  logic [tpat_pkg::WORD-1:0]     req_primary_col_z,
   input  logic [tpat_pkg::WORD-1:0]     req_primary_origin,
   input  logic [tpat_pkg::WORD-1:0]     req_secondary_origin,
   output logic                          rsp_strobe,
   output logic [tpat_pkg::WORD-1:0]     rsp_out_col_x,
   output logic [tpat_pkg::WORD-1:0]     rsp_out_col_y,
   output logic [tpat_pkg::WORD-1:0]     rsp_out_col_z,
   output logic [tpat_pkg::WORD-1:0]     rsp_out_origin,
   output logic                          rsp_fell_back,
   output logic                          rsp_used_alt_hint,
   input  logic                          csr_write_en,
   input  logic [2:0]                    csr_index,
   input  logic [tpat_pkg::WORD-1:0]     csr_wdata
);
   import tpat_pkg::*;

   localparam int DLY = 2 * NORM_LAT + 2;
   localparam int PRW = 2 * CB;
   localparam int ACW = PRW + 2;

   typedef struct packed {
      logic                 fb;
      logic                 alt;
      lane_type [2:0]       p;
      lane_type [2:0][2:0]  prim;
   } side_type;

   typedef struct packed {
      logic [2:0][OW-1:0]   fwd;
      logic [2:0][OW-1:0]   rgt;
   } frame_type;

   // Round half away from zero by the basis fraction bits.
   function automatic logic signed [ACW-BASIS_FRAC:0] rshr(input logic signed [ACW-1:0] v);
      logic [ACW-1:0] mag;
      logic [ACW-1:0] q;
      mag = v[ACW-1] ? (~v + ACW'(1)) : v;
      q   = (mag + (ACW'(1) << (BASIS_FRAC - 1))) >> BASIS_FRAC;
      return v[ACW-1] ? -$signed({1'b0, q[ACW-BASIS_FRAC-1:0]})
                      : $signed({1'b0, q[ACW-BASIS_FRAC-1:0]});
   endfunction

   // Saturate to the signed lane range.
   function automatic lane_type sat(input logic signed [ACW-BASIS_FRAC+1:0] v);
      logic signed [ACW-BASIS_FRAC+1:0] hi;
      logic signed [ACW-BASIS_FRAC+1:0] lo;
      hi = (ACW-BASIS_FRAC+2)'((1 << (CB - 1)) - 1);
      lo = -hi - (ACW-BASIS_FRAC+2)'(1);
      if (v > hi) return lane_type'(hi[CB-1:0]);
      if (v < lo) return lane_type'(lo[CB-1:0]);
      return lane_type'(v[CB-1:0]);
   endfunction

   // Offset registers.
   logic [WORD-1:0]          off_ff [4];

   // Request and first arithmetic stage.
   logic                     s0_valid_ff, s1_valid_ff;
   logic [WORD-1:0]          s0_col_ff [3];
   logic [WORD-1:0]          s0_p_ff, s0_s_ff;
   logic signed [CB:0]       d_in [3];
   logic                     fb_in, alt_in;
   side_type                 s1_side_in, s1_side_ff;
   logic [2:0][NV-1:0]       s1_d_ff, s1_t_ff;

   // Normalizers and cross product.
   logic                     f_valid, r_valid, u_valid;
   logic [2:0][OW-1:0]       f_vec, r_vec, u_vec;
   logic                     x1_valid_ff, x2_valid_ff;
   logic signed [2*OW-1:0]   x1_prod_ff [6];
   logic [2:0][NV-1:0]       x2_t_ff;

   // Delay lines that keep the side data with the vector pipeline.
   side_type                 dly_ff [DLY];
   frame_type                bd_ff [NORM_LAT+2];

   // Compose stages.
   lane_type                 bsel_in [3][3];
   lane_type                 offl_in [4][3];
   logic                     c1_valid_ff, c2_valid_ff, c3_valid_ff;
   logic signed [PRW-1:0]    c1_prod_ff [4][3][3];
   logic signed [ACW-1:0]    c2_acc_ff [4][3];
   lane_type                 c1_p_ff [3];
   lane_type                 c2_p_ff [3];
   logic                     c1_fb_ff, c1_alt_ff, c2_fb_ff, c2_alt_ff;
   lane_type                 res_in [4][3];
   logic [WORD-1:0]          c3_word_ff [4];
   logic                     c3_fb_ff, c3_alt_ff;

   assign busy = 1'b0;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[2'(CSR_OFF_COL_X)]  <= WORD'(1) << BASIS_FRAC;
         off_ff[2'(CSR_OFF_COL_Y)]  <= WORD'(1) << (BASIS_FRAC + CB);
         off_ff[2'(CSR_OFF_COL_Z)]  <= WORD'(1) << (BASIS_FRAC + 2 * CB);
         off_ff[2'(CSR_OFF_ORIGIN)] <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OFF_COL_X:  off_ff[2'(CSR_OFF_COL_X)]  <= csr_wdata;
            CSR_OFF_COL_Y:  off_ff[2'(CSR_OFF_COL_Y)]  <= csr_wdata;
            CSR_OFF_COL_Z:  off_ff[2'(CSR_OFF_COL_Z)]  <= csr_wdata;
            CSR_OFF_ORIGIN: off_ff[2'(CSR_OFF_ORIGIN)] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits of the top-level stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         x1_valid_ff <= 1'b0;
         x2_valid_ff <= 1'b0;
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
         s1_valid_ff <= s0_valid_ff;
         x1_valid_ff <= f_valid;
         x2_valid_ff <= x1_valid_ff;
         c1_valid_ff <= u_valid;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
      end
   end

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      s0_col_ff[0] <= req_primary_col_x;
      s0_col_ff[1] <= req_primary_col_y;
      s0_col_ff[2] <= req_primary_col_z;
      s0_p_ff      <= req_primary_origin;
      s0_s_ff      <= req_secondary_origin;
   end

   // Raw difference, coincidence check and up-hint choice.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = $signed({s0_s_ff[i*CB+CB-1], s0_s_ff[i*CB +: CB]})
                 - $signed({s0_p_ff[i*CB+CB-1], s0_p_ff[i*CB +: CB]});
         s1_side_in.p[i] = s0_p_ff[i*CB +: CB];
         for (int r = 0; r < 3; r++) begin
            s1_side_in.prim[i][r] = s0_col_ff[i][r*CB +: CB];
         end
      end
      fb_in = (d_in[0] == '0) && (d_in[1] == '0) && (d_in[2] == '0);
      alt_in = (d_in[0] == '0) && (d_in[2] == '0) && !fb_in;
      s1_side_in.fb  = fb_in;
      s1_side_in.alt = alt_in;
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      for (int i = 0; i < 3; i++) begin
         s1_d_ff[i] <= NV'(d_in[i]);
      end
      if (alt_in) begin
         s1_t_ff[0] <= NV'(-d_in[1]);
         s1_t_ff[1] <= '0;
         s1_t_ff[2] <= '0;
      end else begin
         s1_t_ff[0] <= NV'(d_in[2]);
         s1_t_ff[1] <= '0;
         s1_t_ff[2] <= NV'(-d_in[0]);
      end
   end

   // Forward and right axes.
   tpat_vnorm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_vec    (s1_d_ff),
      .out_valid (f_valid),
      .out_vec   (f_vec)
   );

   tpat_vnorm u_norm_rgt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_vec    (s1_t_ff),
      .out_valid (r_valid),
      .out_vec   (r_vec)
   );

   // Up = forward x right: products, then differences.
   always_ff @(posedge clock) begin
      x1_prod_ff[0] <= $signed(f_vec[1]) * $signed(r_vec[2]);
      x1_prod_ff[1] <= $signed(f_vec[2]) * $signed(r_vec[1]);
      x1_prod_ff[2] <= $signed(f_vec[2]) * $signed(r_vec[0]);
      x1_prod_ff[3] <= $signed(f_vec[0]) * $signed(r_vec[2]);
      x1_prod_ff[4] <= $signed(f_vec[0]) * $signed(r_vec[1]);
      x1_prod_ff[5] <= $signed(f_vec[1]) * $signed(r_vec[0]);
      for (int i = 0; i < 3; i++) begin
         x2_t_ff[i] <= NV'(x1_prod_ff[2*i]) - NV'(x1_prod_ff[2*i+1]);
      end
   end

   tpat_vnorm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x2_valid_ff),
      .in_vec    (x2_t_ff),
      .out_valid (u_valid),
      .out_vec   (u_vec)
   );

   // Side data and first two axes ride along until the up axis is ready.
   always_ff @(posedge clock) begin
      dly_ff[0]    <= s1_side_ff;
      bd_ff[0].fwd <= f_vec;
      bd_ff[0].rgt <= r_vec;
      for (int i = 1; i < DLY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
      for (int i = 1; i < NORM_LAT + 2; i++) begin
         bd_ff[i] <= bd_ff[i-1];
      end
   end

   // Basis selection: aim frame, or the primary basis when positions coincide.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (dly_ff[DLY-1].fb) begin
            for (int c = 0; c < 3; c++) begin
               bsel_in[c][r] = dly_ff[DLY-1].prim[c][r];
            end
         end else begin
            bsel_in[0][r] = CB'($signed(bd_ff[NORM_LAT+1].rgt[r]));
            bsel_in[1][r] = CB'($signed(u_vec[r]));
            bsel_in[2][r] = CB'($signed(bd_ff[NORM_LAT+1].fwd[r]));
         end
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            offl_in[j][k] = off_ff[j][k*CB +: CB];
         end
      end
   end

   // Compose with the offset: products, sums, then round, add the origin and saturate.
   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               c1_prod_ff[j][r][k] <= bsel_in[k][r] * offl_in[j][k];
            end
            c2_acc_ff[j][r] <= ACW'(c1_prod_ff[j][r][0]) + ACW'(c1_prod_ff[j][r][1])
                             + ACW'(c1_prod_ff[j][r][2]);
         end
      end
      for (int r = 0; r < 3; r++) begin
         c1_p_ff[r] <= dly_ff[DLY-1].p[r];
         c2_p_ff[r] <= c1_p_ff[r];
      end
      c1_fb_ff  <= dly_ff[DLY-1].fb;
      c1_alt_ff <= dly_ff[DLY-1].alt;
      c2_fb_ff  <= c1_fb_ff;
      c2_alt_ff <= c1_alt_ff;
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int r = 0; r < 3; r++) begin
            if (j == 3) begin
               res_in[j][r] = sat((ACW-BASIS_FRAC+2)'(rshr(c2_acc_ff[j][r]))
                                  + (ACW-BASIS_FRAC+2)'(c2_p_ff[r]));
            end else begin
               res_in[j][r] = sat((ACW-BASIS_FRAC+2)'(rshr(c2_acc_ff[j][r])));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 4; j++) begin
         c3_word_ff[j] <= WORD'({res_in[j][2], res_in[j][1], res_in[j][0]});
      end
      c3_fb_ff  <= c2_fb_ff;
      c3_alt_ff <= c2_alt_ff;
   end

   assign rsp_strobe        = c3_valid_ff;
   assign rsp_out_col_x     = c3_word_ff[0];
   assign rsp_out_col_y     = c3_word_ff[1];
   assign rsp_out_col_z     = c3_word_ff[2];
   assign rsp_out_origin    = c3_word_ff[3];
   assign rsp_fell_back     = c3_fb_ff;
   assign rsp_used_alt_hint = c3_alt_ff;

   // The forward and right normalizers run in lockstep.
   `TPAT_ASSERT_NOW(a_norm_lockstep, clock, reset, 1'b1, f_valid == r_valid)
   // A fallback result never reports the alternate up hint.
   `TPAT_ASSERT_NOW(a_fb_no_alt, clock, reset, rsp_strobe && rsp_fell_back, !rsp_used_alt_hint)
   // Valid compose sums are always followed by a result strobe.
   `TPAT_ASSERT_NEXT(a_result_follows, clock, reset, c2_valid_ff, rsp_strobe)

endmodule
